// ===== sv/ssrl_pkg.sv =====
`default_nettype none

package ssrl_pkg;

    // field widths fixed by the word format
    localparam int ADDR_BITS  = 32;
    localparam int SIZE_BITS  = 32;
    localparam int SLACK_BITS = 16;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    // default table shape
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int HANDLE_BITS_DEF = 10;

    // reset value of the unsized slack window
    localparam logic [SLACK_BITS-1:0] SLACK_RESET = 16'h0200;

    // register index, taken from paddr[2]
    localparam logic REG_UNSIZED_SLACK = 1'b0;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_HANDLE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_ZERO_ADDR = 2'd3
    } status_t;

    // which predicate a binary search step evaluates
    typedef enum logic [1:0] {
        SK_INSERT = 2'd0,
        SK_UPPER  = 2'd1,
        SK_FIRST  = 2'd2
    } search_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_SRCH_RD  = 4'd1,
        ST_SRCH_CHK = 4'd2,
        ST_TIE_RD   = 4'd3,
        ST_HIT_RD   = 4'd4,
        ST_SHIFT_RD = 4'd5,
        ST_SHIFT_WR = 4'd6,
        ST_SCAN     = 4'd7,
        ST_RESP     = 4'd8
    } state_t;

endpackage

`default_nettype wire

// ===== sv/ssrl_ram.sv =====
`default_nettype none

module ssrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sorted_symbol_range_lookup.sv =====
// Sorted symbol table with floor lookup.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the command (insert,
// lookup by address, address of handle, clear), s_tdata the address, size and
// name handle. Each word gives exactly one result word on m_tvalid/m_tready with
// a status in m_tuser and handle, offset, address and entry count in m_tdata.
// Entries live in one memory with a single registered read port, and one word
// is worked on at a time. Work per word:
//   lookup        two binary searches
//   insert        entries above the slot moved up by one place
//   handle query  one read per cycle, first match stops the scan
//   clear         entry count set to zero
// The result goes to an output register, so a new word is taken as soon as the
// engine is idle even when the previous result still waits. If the receiver
// stalls with a result still held, the next result waits in the engine.
// After reset the table is empty and unsized_slack is 512; the memory needs no
// clearing pass. unsized_slack is written over the APB port at byte address 0.
`default_nettype none

module sorted_symbol_range_lookup
    import ssrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1),
    localparam int IN_BITS    = ((ADDR_BITS + SIZE_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW    = HANDLE_BITS + ADDR_BITS + ADDR_BITS + CNT_BITS,
    localparam int OUT_BITS   = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input word stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // address, sym_size, name_handle (low to high)
    input  wire logic [IN_BITS-1:0]    s_tdata,
    // command
    input  wire logic [1:0]            s_tuser,
    // result word stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // found_handle, offset, found_address, entry_count (low to high)
    output logic      [OUT_BITS-1:0]   m_tdata,
    // status
    output logic      [1:0]            m_tuser,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int MEM_BITS = ADDR_BITS + SIZE_BITS + HANDLE_BITS;

    // control state
    state_t                state_reg,   state_next;
    search_kind_t          kind_reg,    kind_next;
    logic [CNT_BITS-1:0]   held_reg,    held_next;
    logic [CNT_BITS-1:0]   lo_reg,      lo_next;
    logic [CNT_BITS-1:0]   hi_reg,      hi_next;
    logic [CNT_BITS-1:0]   mid_reg,     mid_next;
    logic [CNT_BITS-1:0]   sh_idx_reg,  sh_idx_next;
    logic [CNT_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [SLACK_BITS-1:0] slack_reg;

    // payload
    logic [ADDR_BITS-1:0]   key_start_reg,  key_start_next;
    logic [SIZE_BITS-1:0]   key_size_reg,   key_size_next;
    logic [HANDLE_BITS-1:0] key_handle_reg, key_handle_next;
    logic [ADDR_BITS-1:0]   tie_start_reg,  tie_start_next;
    status_t                res_status_reg, res_status_next;
    logic [HANDLE_BITS-1:0] res_handle_reg, res_handle_next;
    logic [ADDR_BITS-1:0]   res_offset_reg, res_offset_next;
    logic [ADDR_BITS-1:0]   res_faddr_reg,  res_faddr_next;
    status_t                out_status_reg, out_status_next;
    logic [OUT_BITS-1:0]    out_data_reg,   out_data_next;

    // memory port
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [MEM_BITS-1:0]   mem_wdata;
    logic                  mem_re;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [MEM_BITS-1:0]   mem_rdata;

    // read data fields
    logic [ADDR_BITS-1:0]   rd_start;
    logic [SIZE_BITS-1:0]   rd_size;
    logic [HANDLE_BITS-1:0] rd_handle;

    // helpers
    logic [CNT_BITS-1:0]  mid;
    logic [CNT_BITS-1:0]  lo_dec;
    logic [CNT_BITS-1:0]  sh_dec;
    logic                 pred;
    logic [ADDR_BITS-1:0] hit_off;
    logic [SIZE_BITS-1:0] hit_span;
    logic                 cfg_wr;

    ssrl_ram #(
        .WIDTH (MEM_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_start  = mem_rdata[ADDR_BITS-1:0];
    assign rd_size   = mem_rdata[ADDR_BITS +: SIZE_BITS];
    assign rd_handle = mem_rdata[ADDR_BITS + SIZE_BITS +: HANDLE_BITS];

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_dec = lo_reg - 1'b1;
    assign sh_dec = sh_idx_reg - 1'b1;

    // search predicate: true once the probed entry lies at or past the answer
    always_comb
    begin
        case (kind_reg)
            SK_INSERT:
            begin
                if (rd_start != key_start_reg)
                begin
                    pred = rd_start > key_start_reg;
                end
                else
                begin
                    pred = rd_size < key_size_reg;
                end
            end
            SK_UPPER: pred = rd_start > key_start_reg;
            SK_FIRST: pred = rd_start >= tie_start_reg;
            default:  pred = 1'b1;
        endcase
    end

    // range check of the chosen entry
    assign hit_off  = key_start_reg - rd_start;
    assign hit_span = (rd_size != '0) ? rd_size : SIZE_BITS'(slack_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        held_next       = held_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        sh_idx_next     = sh_idx_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = chk_vld_reg;
        key_start_next  = key_start_reg;
        key_size_next   = key_size_reg;
        key_handle_next = key_handle_reg;
        tie_start_next  = tie_start_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_offset_next = res_offset_reg;
        res_faddr_next  = res_faddr_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_we          = 1'b0;
        mem_waddr       = lo_reg[IDX_BITS-1:0];
        mem_wdata       = {key_handle_reg, key_size_reg, key_start_reg};
        mem_re          = 1'b0;
        mem_raddr       = mid[IDX_BITS-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_start_next  = {s_tdata[ADDR_BITS-1:1], 1'b0};
                    key_size_next   = s_tdata[ADDR_BITS +: SIZE_BITS];
                    key_handle_next = s_tdata[ADDR_BITS + SIZE_BITS +: HANDLE_BITS];
                    res_status_next = STS_OK;
                    res_handle_next = '0;
                    res_offset_next = '0;
                    res_faddr_next  = '0;
                    lo_next         = '0;
                    hi_next         = held_reg;
                    case (cmd_t'(s_tuser))
                        CMD_INSERT:
                        begin
                            if (s_tdata[ADDR_BITS-1:1] == '0)
                            begin
                                res_status_next = STS_ZERO_ADDR;
                                state_next      = ST_RESP;
                            end
                            else if (held_reg == CNT_BITS'(TABLE_DEPTH))
                            begin
                                res_status_next = STS_FULL;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                kind_next  = SK_INSERT;
                                state_next = ST_SRCH_RD;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            kind_next  = SK_UPPER;
                            state_next = ST_SRCH_RD;
                        end
                        CMD_HANDLE:
                        begin
                            scan_idx_next = '0;
                            chk_vld_next  = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            held_next  = '0;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            held_next  = '0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // issue a probe, or finish the search
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid[IDX_BITS-1:0];
                    mid_next   = mid;
                    state_next = ST_SRCH_CHK;
                end
                else
                begin
                    case (kind_reg)
                        SK_INSERT:
                        begin
                            sh_idx_next = held_reg;
                            state_next  = ST_SHIFT_RD;
                        end
                        SK_UPPER:
                        begin
                            if (lo_reg == '0)
                            begin
                                res_status_next = STS_NOT_FOUND;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                // fetch the floor entry to learn its start
                                mem_re     = 1'b1;
                                mem_raddr  = lo_dec[IDX_BITS-1:0];
                                hi_next    = lo_dec;
                                lo_next    = '0;
                                state_next = ST_TIE_RD;
                            end
                        end
                        SK_FIRST:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = lo_reg[IDX_BITS-1:0];
                            state_next = ST_HIT_RD;
                        end
                        default:
                        begin
                            res_status_next = STS_NOT_FOUND;
                            state_next      = ST_RESP;
                        end
                    endcase
                end
            end

            // narrow the window with the probed entry
            ST_SRCH_CHK:
            begin
                if (pred)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = ST_SRCH_RD;
            end

            // second search: first entry sharing the floor start
            ST_TIE_RD:
            begin
                tie_start_next = rd_start;
                kind_next      = SK_FIRST;
                state_next     = ST_SRCH_RD;
            end

            ST_HIT_RD:
            begin
                if (hit_off < hit_span)
                begin
                    res_handle_next = rd_handle;
                    res_offset_next = hit_off;
                end
                else
                begin
                    res_status_next = STS_NOT_FOUND;
                end
                state_next = ST_RESP;
            end

            // move entries up one place, from the top down to the slot
            ST_SHIFT_RD:
            begin
                if (sh_idx_reg > lo_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sh_dec[IDX_BITS-1:0];
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = lo_reg[IDX_BITS-1:0];
                    held_next  = held_reg + 1'b1;
                    state_next = ST_RESP;
                end
            end

            ST_SHIFT_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = sh_idx_reg[IDX_BITS-1:0];
                mem_wdata   = mem_rdata;
                sh_idx_next = sh_dec;
                state_next  = ST_SHIFT_RD;
            end

            // linear scan, one read per cycle, check the previous read
            ST_SCAN:
            begin
                if (chk_vld_reg && (rd_handle == key_handle_reg))
                begin
                    res_faddr_next = rd_start;
                    state_next     = ST_RESP;
                end
                else if (scan_idx_reg < held_reg)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_idx_reg[IDX_BITS-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    chk_vld_next  = 1'b1;
                end
                else
                begin
                    res_status_next = STS_NOT_FOUND;
                    state_next      = ST_RESP;
                end
            end

            // hand the result to the output register once it is free
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = OUT_BITS'({held_reg, res_faddr_reg,
                                                 res_offset_reg, res_handle_reg});
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kind_reg     <= SK_INSERT;
            held_reg     <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            sh_idx_reg   <= '0;
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            slack_reg    <= SLACK_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            held_reg     <= held_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            sh_idx_reg   <= sh_idx_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr)
            begin
                slack_reg <= pwdata[SLACK_BITS-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_start_reg  <= key_start_next;
        key_size_reg   <= key_size_next;
        key_handle_reg <= key_handle_next;
        tie_start_reg  <= tie_start_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_offset_reg <= res_offset_next;
        res_faddr_reg  <= res_faddr_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_UNSIZED_SLACK);
    assign prdata = (paddr[2] == REG_UNSIZED_SLACK) ? PDATA_BITS'(slack_reg) : '0;

    // stream ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // entry count stays within the table
    a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // search window never inverts
    a_window : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_RD || state_reg == ST_SRCH_CHK) |-> lo_reg <= hi_reg)
        else $error("binary search window inverted");

    // the table is written only while an insert moves or places entries
    a_write_phase : assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SHIFT_RD || state_reg == ST_SHIFT_WR))
        else $error("table write outside insert");

    // entry count changes only on clear or on placing an insert
    a_held_change : assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_SHIFT_RD))
        else $error("entry count changed unexpectedly");

endmodule

`default_nettype wire

// ===== tb/sv/ssrl_checker.sv =====
`default_nettype none

module ssrl_checker
    import ssrl_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int HBITS = HANDLE_BITS_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IN_W  = ((ADDR_BITS + SIZE_BITS + HBITS + 7) / 8) * 8,
    parameter int OUT_W = ((HBITS + 2 * ADDR_BITS + CNT_W + 7) / 8) * 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // address, sym_size, name_handle (low to high)
    input  wire logic [IN_W-1:0]       s_tdata,
    // command
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // found_handle, offset, found_address, entry_count (low to high)
    input  wire logic [OUT_W-1:0]      m_tdata,
    // status
    input  wire logic [1:0]            m_tuser,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    input  wire logic [PDATA_BITS-1:0] prdata,
    input  wire logic                  pready,
    output int                         pending,
    output int                         errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                status;
        logic [HBITS-1:0]       handle;
        logic [ADDR_BITS-1:0]   offset;
        logic [ADDR_BITS-1:0]   start;
        logic [CNT_W-1:0]       count;
    } table_reply_t;

    // shadow copy of the symbol table and the slack register
    logic [ADDR_BITS-1:0]  sym_start  [DEPTH];
    logic [SIZE_BITS-1:0]  sym_size   [DEPTH];
    logic [HBITS-1:0]      sym_handle [DEPTH];
    int                    held;
    logic [SLACK_BITS-1:0] slack;

    table_reply_t awaited_replies[$];
    int           waiting    = 0;
    int           fail_tally = 0;

    assign pending = waiting;
    assign errors  = fail_tally;

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_tally++;
        end
    endtask

    // apply one command word to the shadow table and work out its reply
    task automatic apply_command(input cmd_t cmd, input logic [ADDR_BITS-1:0] addr,
                                 input logic [SIZE_BITS-1:0] size,
                                 input logic [HBITS-1:0] hdl, output table_reply_t rep);
        logic [ADDR_BITS-1:0] key;
        logic [SIZE_BITS-1:0] span;
        int pos;
        int i;
        int lo;
        int hi;
        int mid;
        int k;
        bit hit;
        rep        = '0;
        rep.status = STS_OK;
        key        = {addr[ADDR_BITS-1:1], 1'b0};
        case (cmd)
            CMD_INSERT:
            begin
                if (key == '0)
                    rep.status = STS_ZERO_ADDR;
                else if (held >= DEPTH)
                    rep.status = STS_FULL;
                else
                begin
                    // new entry goes after every entry that does not sort after it
                    pos = 0;
                    while (pos < held && (sym_start[pos] < key ||
                           (sym_start[pos] == key && sym_size[pos] >= size)))
                        pos++;
                    for (i = held; i > pos; i--)
                    begin
                        sym_start[i]  = sym_start[i-1];
                        sym_size[i]   = sym_size[i-1];
                        sym_handle[i] = sym_handle[i-1];
                    end
                    sym_start[pos]  = key;
                    sym_size[pos]   = size;
                    sym_handle[pos] = hdl;
                    held++;
                end
            end
            CMD_LOOKUP:
            begin
                rep.status = STS_NOT_FOUND;
                lo = 0;
                hi = held;
                // upper bound on the start address
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (sym_start[mid] <= key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo > 0)
                begin
                    // walk back to the first of tied starts, the largest size
                    k = lo - 1;
                    while (k > 0 && sym_start[k-1] == sym_start[k])
                        k--;
                    span = (sym_size[k] != '0) ? sym_size[k] : SIZE_BITS'(slack);
                    if (key - sym_start[k] < span)
                    begin
                        rep.status = STS_OK;
                        rep.handle = sym_handle[k];
                        rep.offset = key - sym_start[k];
                    end
                end
            end
            CMD_HANDLE:
            begin
                rep.status = STS_NOT_FOUND;
                hit = 1'b0;
                i = 0;
                while (!hit && i < held)
                begin
                    if (sym_handle[i] == hdl)
                    begin
                        hit        = 1'b1;
                        rep.status = STS_OK;
                        rep.start  = sym_start[i];
                    end
                    i++;
                end
            end
            default:
                held = 0;
        endcase
        rep.count = CNT_W'(held);
    endtask

    // watch both streams and the config port
    always @(posedge clk or negedge rst_n)
    begin : watch
        table_reply_t rep;
        if (!rst_n)
        begin
            held  = 0;
            slack = SLACK_RESET;
            awaited_replies.delete();
            waiting <= 0;
        end
        else
        begin
            // result word against the oldest outstanding reply
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding, expected none, actual %h %h",
                             $time, m_tuser, m_tdata);
                    fail_tally++;
                end
                else
                begin
                    rep = awaited_replies.pop_front();
                    compare_field("status", 32'(rep.status), 32'(m_tuser));
                    compare_field("found_handle", 32'(rep.handle), 32'(m_tdata[HBITS-1:0]));
                    compare_field("offset", rep.offset, m_tdata[HBITS +: ADDR_BITS]);
                    compare_field("found_address", rep.start,
                                  m_tdata[HBITS + ADDR_BITS +: ADDR_BITS]);
                    compare_field("entry_count", 32'(rep.count),
                                  32'(m_tdata[HBITS + 2 * ADDR_BITS +: CNT_W]));
                end
            end
            // command word
            if (s_tvalid && s_tready)
            begin
                apply_command(cmd_t'(s_tuser), s_tdata[0 +: ADDR_BITS],
                              s_tdata[ADDR_BITS +: SIZE_BITS],
                              s_tdata[ADDR_BITS + SIZE_BITS +: HBITS], rep);
                awaited_replies.push_back(rep);
            end
            // register access
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_UNSIZED_SLACK)
                        slack = pwdata[SLACK_BITS-1:0];
                end
                else
                    compare_field("prdata", PDATA_BITS'(slack), prdata);
            end
            waiting <= awaited_replies.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    import ssrl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = $clog2(TABLE_DEPTH_DEF + 1);
    localparam int IN_W  = ((ADDR_BITS + SIZE_BITS + HANDLE_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_W = ((HANDLE_BITS_DEF + 2 * ADDR_BITS + CNT_W + 7) / 8) * 8;
    localparam logic [PADDR_BITS-1:0] SLACK_ADDR = {REG_UNSIZED_SLACK, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // address, sym_size, name_handle (low to high)
    logic [IN_W-1:0]       s_tdata;
    // command
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // found_handle, offset, found_address, entry_count (low to high)
    logic [OUT_W-1:0]      m_tdata;
    // status
    logic [1:0]            m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    errors;

    // no idle cycles on either side while set
    bit burst = 1'b0;

    // starts and handles placed since the last clear, used to aim stimulus
    logic [ADDR_BITS-1:0]       placed_starts[$];
    logic [HANDLE_BITS_DEF-1:0] placed_handles[$];

    sorted_symbol_range_lookup uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ssrl_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pending  (pending),
        .errors   (errors)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stall before taking each word
    initial
    begin : result_sink
        int gap;
        m_tready <= 1'b0;
        forever
        begin
            gap = burst ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // send one command word after a random gap
    task automatic send_word(input cmd_t cmd, input logic [ADDR_BITS-1:0] addr,
                             input logic [SIZE_BITS-1:0] size,
                             input logic [HANDLE_BITS_DEF-1:0] hdl);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_W'({hdl, size, addr});
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_INSERT && addr[ADDR_BITS-1:1] != '0)
        begin
            placed_starts.push_back({addr[ADDR_BITS-1:1], 1'b0});
            placed_handles.push_back(hdl);
        end
        else if (cmd == CMD_CLEAR)
        begin
            placed_starts.delete();
            placed_handles.delete();
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // one apb transfer to the slack register
    task automatic slack_access(input logic wr, input logic [PDATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SLACK_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int ph;
        int n;
        int r;
        int pick;
        int idx;
        int i;
        cmd_t c;
        logic [ADDR_BITS-1:0] a;
        logic [SIZE_BITS-1:0] sz;
        logic [HANDLE_BITS_DEF-1:0] h;
        logic [PDATA_BITS-1:0] slack_plan [4];

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_INSERT;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of the slack register
        slack_access(1'b0, '0);

        // empty table, zero address, bit zero, tied starts
        send_word(CMD_LOOKUP, 32'h0000_1000, 32'h0, 10'd0);
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'd3);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h10, 10'd1);
        send_word(CMD_INSERT, 32'h0000_0001, 32'h10, 10'd2);
        send_word(CMD_INSERT, 32'h0000_1001, 32'h10, 10'h3FF);
        send_word(CMD_INSERT, 32'h0000_1000, 32'h100, 10'd5);
        send_word(CMD_INSERT, 32'h0000_1000, 32'h10, 10'd7);
        send_word(CMD_INSERT, 32'h0000_2000, 32'h0, 10'd9);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0);
        // hits, misses past the size and the slack window, below the first entry
        send_word(CMD_LOOKUP, 32'h0000_1001, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_10FF, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_1100, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_0FFF, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_21FF, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_2200, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        // handle queries: first match, absent handle
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'd7);
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'h3FF);
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'd100);
        send_word(CMD_CLEAR, 32'h0, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_1000, 32'h0, 10'd0);

        // zero slack: unsized entries never match
        drain();
        slack_access(1'b1, 32'h0);
        slack_access(1'b0, '0);
        send_word(CMD_INSERT, 32'h0000_3000, 32'h0, 10'd1);
        send_word(CMD_LOOKUP, 32'h0000_3000, 32'h0, 10'd0);
        // widest slack window
        drain();
        slack_access(1'b1, 32'h0000_FFFF);
        send_word(CMD_LOOKUP, 32'h0001_2FFF, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0001_3000, 32'h0, 10'd0);
        send_word(CMD_CLEAR, 32'h0, 32'h0, 10'd0);

        // random phases over several slack settings
        slack_plan[0] = 32'h0000_FFFF;
        slack_plan[1] = 32'h0000_0001;
        slack_plan[2] = 32'($urandom_range(0, 65535));
        slack_plan[3] = {16'($urandom_range(1, 65535)), 16'h0200};
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            slack_access(1'b1, slack_plan[ph]);
            slack_access(1'b0, '0);
            for (n = 0; n < 213; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    burst = !burst;
                r  = $urandom_range(0, 99);
                h  = HANDLE_BITS_DEF'($urandom_range(0, 1023));
                if ($urandom_range(0, 2) == 0)
                    h = HANDLE_BITS_DEF'($urandom_range(0, 15));
                a  = $urandom;
                sz = $urandom;
                if (placed_starts.size() >= 48 || r >= 96)
                    c = CMD_CLEAR;
                else if (r < 42)
                begin
                    c    = CMD_INSERT;
                    pick = $urandom_range(0, 19);
                    if (pick < 5 && placed_starts.size() != 0)
                    begin
                        idx = $urandom_range(0, placed_starts.size() - 1);
                        a   = placed_starts[idx] | 32'($urandom_range(0, 1));
                    end
                    else if (pick < 15)
                        a = 32'h0001_0000 + $urandom_range(0, 4095);
                    else if (pick >= 18)
                        a = $urandom_range(0, 3);
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        sz = '0;
                    else if (pick < 8)
                        sz = $urandom_range(1, 256);
                end
                else if (r < 82)
                begin
                    c = CMD_LOOKUP;
                    if (placed_starts.size() != 0 && $urandom_range(0, 4) != 0)
                    begin
                        idx = $urandom_range(0, placed_starts.size() - 1);
                        a   = placed_starts[idx] + $urandom_range(0, 300);
                        if ($urandom_range(0, 3) == 0)
                            a = a - $urandom_range(1, 8);
                    end
                end
                else
                begin
                    c = CMD_HANDLE;
                    if (placed_handles.size() != 0 && $urandom_range(0, 1) == 0)
                    begin
                        idx = $urandom_range(0, placed_handles.size() - 1);
                        h   = placed_handles[idx];
                    end
                end
                send_word(c, a, sz, h);
                if ($urandom_range(0, 59) == 0)
                    drain();
            end
        end

        // fill the table in ascending order, then push past full
        drain();
        burst = 1'b0;
        send_word(CMD_CLEAR, 32'h0, 32'h0, 10'd0);
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
        begin
            sz = (i % 3 == 0) ? '0 : SIZE_BITS'($urandom_range(1, 16));
            send_word(CMD_INSERT, 32'h100 + 32'(i * 16) + 32'(i % 2), sz,
                      HANDLE_BITS_DEF'(i));
        end
        send_word(CMD_INSERT, 32'h0000_0100, 32'h20, 10'd1);
        send_word(CMD_INSERT, 32'h0000_0005, 32'h0, 10'd2);
        send_word(CMD_INSERT, 32'h0000_0001, 32'h0, 10'd3);
        for (i = 0; i < 20; i++)
            send_word(CMD_LOOKUP, 32'h100 + $urandom_range(0, 16 * 1024 + 600),
                      $urandom, HANDLE_BITS_DEF'($urandom_range(0, 1023)));
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'd0);
        send_word(CMD_HANDLE, 32'h0, 32'h0, 10'h3FF);
        send_word(CMD_CLEAR, 32'h0, 32'h0, 10'd0);
        send_word(CMD_LOOKUP, 32'h0000_0100, 32'h0, 10'd0);

        // let everything come out, then give the verdict
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
